/* hw/rtl/sspc_pkg.sv */
// ----------------------------------------------------------------------------
// Sensor sentence parser package
// Shared constants and types for the ASCII sensor sentence parser.
// ----------------------------------------------------------------------------
package sspc_pkg;

  localparam int unsigned MaxFrameLenDef = 256;
  localparam int unsigned MinTailPosDef  = 10;

  localparam int unsigned ValW  = 16;
  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] CharDollar = 8'h24;
  localparam logic [ByteW-1:0] CharStar   = 8'h2A;
  localparam logic [ByteW-1:0] CharPlus   = 8'h2B;
  localparam logic [ByteW-1:0] CharComma  = 8'h2C;
  localparam logic [ByteW-1:0] CharMinus  = 8'h2D;
  localparam logic [ByteW-1:0] CharPoint  = 8'h2E;
  localparam logic [ByteW-1:0] CharZero   = 8'h30;
  localparam logic [ByteW-1:0] CharNine   = 8'h39;
  localparam logic [ByteW-1:0] CharUpC    = 8'h43;
  localparam logic [ByteW-1:0] CharUpI    = 8'h49;
  localparam logic [ByteW-1:0] CharUpP    = 8'h50;
  localparam logic [ByteW-1:0] CharUpR    = 8'h52;
  localparam logic [ByteW-1:0] CharUpS    = 8'h53;
  localparam logic [ByteW-1:0] CharSpace  = 8'h20;
  localparam logic [ByteW-1:0] CharTab    = 8'h09;
  localparam logic [ByteW-1:0] CharCr     = 8'h0D;

  typedef struct packed {
    logic            fire;
    logic            att;
    logic [ValW-1:0] v0;
    logic [ValW-1:0] v1;
    logic [ValW-1:0] v2;
  } sspc_close_t;

  typedef struct packed {
    logic neg;
    logic point;
    logic digit;
    logic tenth;
  } sspc_flags_t;

endpackage

/* hw/rtl/sensor_sentence_parser_core.sv */
// A result passes the input register and then the result register once the
// request that closes its frame is accepted; a full result register holds it.
// Throughput: one byte or tick per cycle unless the output stalls; the parser
// state is registered. A stalled output stalls the input only once both the
// input and result registers are full.
// Reset clears the framer to idle, the tick counters and both valid flags.
// ----------------------------------------------------------------------------
// Sensor sentence parser core
// Frames depth and attitude sentences from a byte stream, decodes their
// fields to tenths and stamps each result with the tick interval.
// ----------------------------------------------------------------------------
module sensor_sentence_parser_core
  import sspc_pkg::*;
#(
  parameter int unsigned MaxFrameLen = MaxFrameLenDef,
  parameter int unsigned MinTailPos  = MinTailPosDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
  input  logic       s_axis_tuser,  // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  // [15:0] depth_tenths, [31:16] heading_tenths, [47:32] pitch_tenths,
  // [63:48] roll_tenths, [79:64] interval_ticks
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser  // [0] frame_type
);

  logic             in_vld_q;
  logic             in_kind_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_free;
  logic             advance;
  logic             byte_en;
  sspc_close_t      close;
  logic [ValW-1:0]  tick_q;
  logic [ValW-1:0]  last_depth_q;
  logic [ValW-1:0]  last_att_q;
  logic             out_vld_q;
  logic             out_type_q;
  logic [79:0]      out_data_q;
  logic             emit;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign byte_en       = advance && !in_kind_q;
  assign emit          = byte_en && close.fire;

  sspc_frame #(
    .MaxFrameLen(MaxFrameLen),
    .MinTailPos (MinTailPos)
  ) u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_en_i(byte_en),
    .byte_i   (in_byte_q),
    .close_o  (close)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      last_depth_q <= '0;
      last_att_q   <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (advance && in_kind_q) begin
        tick_q <= tick_q + 1'b1;
      end
      if (out_free) begin
        out_vld_q <= emit;
      end
      if (emit) begin
        if (close.att) last_att_q <= tick_q;
        else last_depth_q <= tick_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_type_q <= close.att;
      if (close.att) begin
        out_data_q <= {tick_q - last_att_q, close.v2, close.v1, close.v0, {ValW{1'b0}}};
      end else begin
        out_data_q <= {tick_q - last_depth_q, {(3*ValW){1'b0}}, close.v0};
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_type_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/sspc_frame.sv */
// ----------------------------------------------------------------------------
// Sentence framer and decoder
// Tracks the frame position, walks the sentence syntax one byte at a time and
// accumulates the decimal fields; reports a decoded frame when it closes.
// ----------------------------------------------------------------------------
module sspc_frame
  import sspc_pkg::*;
#(
  parameter int unsigned MaxFrameLen = MaxFrameLenDef,
  parameter int unsigned MinTailPos  = MinTailPosDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_en_i,
  input  logic [ByteW-1:0] byte_i,
  output sspc_close_t      close_o
);

  localparam int unsigned PosW = $clog2(MaxFrameLen);
  localparam logic [PosW-1:0] PosLast = PosW'(MaxFrameLen - 1);
  localparam logic [PosW-1:0] TailPos = PosW'(MinTailPos);

  localparam logic [3:0] PhClass = 4'd0;
  localparam logic [3:0] PhI     = 4'd1;
  localparam logic [3:0] PhP     = 4'd2;
  localparam logic [3:0] PhS     = 4'd3;
  localparam logic [3:0] PhComma = 4'd4;
  localparam logic [3:0] PhDLead = 4'd5;
  localparam logic [3:0] PhDBody = 4'd6;
  localparam logic [3:0] PhALead = 4'd7;
  localparam logic [3:0] PhABody = 4'd8;
  localparam logic [3:0] PhDone  = 4'd9;

  logic [PosW-1:0] pos_q, pos_d;
  logic            att_q, att_d;
  logic [3:0]      phase_q, phase_d;
  logic [1:0]      fidx_q, fidx_d;
  logic [ValW-1:0] acc_q, acc_d;
  sspc_flags_t     flags_q, flags_d;
  logic [ValW-1:0] vals_q [3];
  logic [ValW-1:0] vals_d [3];
  logic            ok_q, ok_d;

  logic            is_digit;
  logic            is_space;
  logic [ValW-1:0] acc_x10;
  logic [ValW-1:0] acc_step;
  logic [ValW-1:0] fin_base;
  logic [ValW-1:0] fin_val;
  logic            body_take;
  logic            in_body;
  logic            in_lead;

  assign is_digit = (byte_i >= CharZero) && (byte_i <= CharNine);
  assign is_space = (byte_i == CharSpace) || ((byte_i >= CharTab) && (byte_i <= CharCr));
  assign acc_x10  = (acc_q << 3) + (acc_q << 1);
  assign acc_step = acc_x10 + {{(ValW-ByteW){1'b0}}, byte_i - CharZero};
  assign fin_base = flags_q.tenth ? acc_q : acc_x10;
  assign fin_val  = flags_q.neg ? (~fin_base + 1'b1) : fin_base;
  assign body_take = is_digit || ((byte_i == CharPoint) && !flags_q.point);
  assign in_body  = (phase_q == PhDBody) || (phase_q == PhABody);
  assign in_lead  = (phase_q == PhDLead) || (phase_q == PhALead);

  always_comb begin
    pos_d   = pos_q;
    att_d   = att_q;
    phase_d = phase_q;
    fidx_d  = fidx_q;
    acc_d   = acc_q;
    flags_d = flags_q;
    vals_d  = vals_q;
    ok_d    = ok_q;
    close_o = '0;
    if (byte_en_i) begin
      if (pos_q == '0) begin
        if (byte_i == CharDollar) begin
          pos_d   = PosW'(1);
          att_d   = 1'b0;
          phase_d = PhClass;
          fidx_d  = 2'd0;
          acc_d   = '0;
          flags_d = '0;
          ok_d    = 1'b1;
        end
      end else if (pos_q >= PosLast) begin
        pos_d = '0;
      end else begin
        if (ok_q) begin
          if ((in_body || (in_lead && !is_space && byte_i != CharPlus &&
                           byte_i != CharMinus)) && body_take) begin
            if (in_lead) begin
              phase_d = (phase_q == PhALead) ? PhABody : PhDBody;
            end
            if (is_digit) begin
              if (!flags_q.point || !flags_q.tenth) begin
                acc_d = acc_step;
                if (flags_q.point) begin
                  flags_d.tenth = 1'b1;
                end
              end
              flags_d.digit = 1'b1;
            end else begin
              flags_d.point = 1'b1;
            end
          end else begin
            unique case (phase_q)
              PhClass: begin
                if (byte_i == CharUpP) begin
                  att_d   = 1'b0;
                  phase_d = PhI;
                end else if (byte_i == CharUpC) begin
                  att_d   = 1'b1;
                  fidx_d  = 2'd0;
                  phase_d = PhALead;
                end else begin
                  ok_d = 1'b0;
                end
              end
              PhI: begin
                if (byte_i == CharUpI) phase_d = PhP;
                else ok_d = 1'b0;
              end
              PhP: begin
                if (byte_i == CharUpP) phase_d = PhS;
                else ok_d = 1'b0;
              end
              PhS: begin
                if (byte_i == CharUpS) phase_d = PhComma;
                else ok_d = 1'b0;
              end
              PhComma: begin
                if (byte_i == CharComma) phase_d = PhDLead;
                else ok_d = 1'b0;
              end
              PhDLead, PhALead: begin
                if (byte_i == CharPlus || byte_i == CharMinus) begin
                  flags_d.neg = flags_q.neg || (byte_i == CharMinus);
                  phase_d     = (phase_q == PhALead) ? PhABody : PhDBody;
                end else if (!is_space) begin
                  ok_d = 1'b0;
                end
              end
              PhDBody, PhABody: begin
                if (!flags_q.digit) begin
                  ok_d = 1'b0;
                end else begin
                  if (fidx_q < 2'd3) begin
                    vals_d[fidx_q] = fin_val;
                  end
                  acc_d   = '0;
                  flags_d = '0;
                  if (phase_q == PhDBody) begin
                    phase_d = PhDone;
                  end else if (fidx_q == 2'd0 && byte_i == CharUpP) begin
                    fidx_d  = 2'd1;
                    phase_d = PhALead;
                  end else if (fidx_q == 2'd1 && byte_i == CharUpR) begin
                    fidx_d  = 2'd2;
                    phase_d = PhALead;
                  end else if (fidx_q == 2'd2) begin
                    phase_d = PhDone;
                  end else begin
                    ok_d = 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        pos_d = pos_q + 1'b1;
        if (byte_i == CharStar && pos_q > TailPos) begin
          pos_d         = '0;
          close_o.fire  = ok_d && (phase_d == PhDone);
          close_o.att   = att_d;
          close_o.v0    = vals_d[0];
          close_o.v1    = vals_d[1];
          close_o.v2    = vals_d[2];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      att_q   <= 1'b0;
      phase_q <= PhClass;
      fidx_q  <= 2'd0;
      acc_q   <= '0;
      flags_q <= '0;
      vals_q  <= '{default: '0};
      ok_q    <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      att_q   <= att_d;
      phase_q <= phase_d;
      fidx_q  <= fidx_d;
      acc_q   <= acc_d;
      flags_q <= flags_d;
      vals_q  <= vals_d;
      ok_q    <= ok_d;
    end
  end

endmodule

/* hw/rtl/sspc_checker.sv */
// ----------------------------------------------------------------------------
// Sensor sentence parser checker
// Port-level assertions on the parser core, bound to the top level.
// ----------------------------------------------------------------------------
module sspc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result request changed.");

  a_depth_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:16] == 48'd0)
    else $error("Depth result carries attitude fields.");

  a_att_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'd0)
    else $error("Attitude result carries a depth field.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("Input stalled while no result is pending.");

  a_rose_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && !s_axis_tuser, 2))
    else $error("Result appeared without a closing byte request.");

endmodule

bind sensor_sentence_parser_core sspc_checker u_sspc_checker (.*);
